// ===== rtl/tdaft_pkg.sv =====
`timescale 1ns / 1ps
// Package for the TCP duplicate-ACK flow table: sequencer states, register map,
// configuration struct and table entry layout. No dependencies.
package tdaft_pkg;

    // register map (byte address 4*index)
    localparam int          CFG_ADDR_W   = 5;
    localparam int          CFG_DATA_W   = 32;
    localparam logic [2:0]  REG_FEATURE  = 3'd0;
    localparam logic [2:0]  REG_LOWER    = 3'd1;
    localparam logic [2:0]  REG_UPPER    = 3'd2;
    localparam logic [2:0]  REG_CEILING  = 3'd3;
    localparam logic [2:0]  REG_FLOOR    = 3'd4;

    localparam logic        RST_FEATURE  = 1'b0;
    localparam logic [15:0] RST_LOWER    = 16'd5;
    localparam logic [15:0] RST_UPPER    = 16'd55;
    localparam logic [3:0]  RST_CEILING  = 4'd10;
    localparam logic [4:0]  RST_FLOOR    = 5'b11110;

    localparam int          SLOT_W       = 5;
    localparam int          TUPLE_W      = 96;
    localparam int          ENTRY_W      = 160;
    localparam logic [31:0] TIME_MAX     = 32'hffff_ffff;

    typedef struct packed {
        logic              feature_enable;
        logic [15:0]       lower_bound_mbps;
        logic [15:0]       upper_bound_mbps;
        logic [3:0]        stick_ceiling;
        logic signed [4:0] stick_floor;
    } tdaft_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_LAST,
        ST_WRITE,
        ST_DONE
    } tdaft_state_t;

endpackage

// ===== rtl/tcp_dup_ack_flow_table.sv =====
`timescale 1ns / 1ps
// TCP duplicate-ACK flow table: top level with scan sequencer and stickiness logic.
// Depends on tdaft_pkg, tdaft_ram and tdaft_regs.
// An ACK while on walks every slot of the table RAM once through its single read port
// in ST_SCAN, then passes ST_LAST and ST_WRITE to ST_DONE; a tick passes ST_TICK and an
// ACK while off goes straight to ST_DONE. One item at a time; the next item is accepted
// once the result is in the output register.
// Reset clears all valid bits, stickiness and the on state at once and loads the
// register defaults; no clearing pass is needed.
module tcp_dup_ack_flow_table
    import tdaft_pkg::*;
#(
    parameter int FLOW_SLOTS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata from bit 0: source_ip[31:0], dest_ip[63:32], source_port[79:64],
    // dest_port[95:80], ack_number[127:96], time_ms[159:128], tx_mbps[175:160],
    // rx_mbps[191:176]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [191:0]          s_tdata,
    // s_tuser: req_type[0] (0 = ACK, 1 = tick)
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: duplicate_ack[0], flow_slot[5:1], new_flow[6],
    // status_changed[7], buffering_on[8], zero[15:9]
    output logic [15:0]           m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(FLOW_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_SLOTS - 1);

    tdaft_cfg_t   cfg;
    tdaft_state_t state_reg, state_next;

    // control
    logic [FLOW_SLOTS-1:0] valid_reg;
    logic signed [4:0]     stick_reg;
    logic                  last_on_reg;
    logic                  out_valid_reg;
    logic [IDX_W-1:0]      iss_reg;
    logic                  pend_reg;
    logic                  hit_found_reg;
    logic                  free_found_reg;

    // payload
    logic                  item_tick_reg;
    logic [TUPLE_W-1:0]    item_tuple_reg;
    logic [31:0]           item_ack_reg;
    logic [31:0]           item_time_reg;
    logic [15:0]           item_tx_reg;
    logic [15:0]           item_rx_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic                  hit_dup_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [IDX_W-1:0]      old_idx_reg;
    logic [31:0]           old_time_reg;
    logic                  res_dup_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic                  res_new_reg;
    logic                  res_chg_reg;
    logic [8:0]            m_data_reg;

    logic                  in_acc;
    logic                  out_load;
    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0]    ram_wr_data;
    logic [ENTRY_W-1:0]    ram_rd_data;
    logic                  is_on;

    logic [IDX_W-1:0]      pick_idx;
    logic [SLOT_W+IDX_W-1:0] pick_wide;

    logic [15:0]           tp;
    logic                  in_band;
    logic signed [5:0]     s_up, s_dn, ceil6, floor6, s_new;
    logic                  on_new;

    tdaft_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tdaft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FLOW_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign is_on    = (stick_reg > 5'sd0);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

    // stickiness update, one saturating step per tick while the feature is enabled
    assign tp      = (item_tx_reg > item_rx_reg) ? item_tx_reg : item_rx_reg;
    assign in_band = (tp > cfg.lower_bound_mbps) && (tp < cfg.upper_bound_mbps);
    assign s_up    = 6'(stick_reg) + 6'sd1;
    assign s_dn    = 6'(stick_reg) - 6'sd1;
    assign ceil6   = $signed({2'b00, cfg.stick_ceiling});
    assign floor6  = {cfg.stick_floor[4], cfg.stick_floor};
    assign s_new   = in_band ? ((s_up > ceil6) ? ceil6 : s_up)
                             : ((s_dn < floor6) ? floor6 : s_dn);
    assign on_new  = (s_new > 6'sd0);

    // slot choice: matched entry, else first free, else oldest
    always_comb
    begin
        priority if (hit_found_reg)
            pick_idx = hit_idx_reg;
        else if (free_found_reg)
            pick_idx = free_idx_reg;
        else
            pick_idx = old_idx_reg;
    end
    assign pick_wide = {{SLOT_W{1'b0}}, pick_idx};

    assign ram_wr_addr = pick_idx;
    assign ram_wr_data = {item_time_reg, item_ack_reg, item_tuple_reg};
    assign ram_rd_addr = iss_reg;

    always_comb
    begin
        state_next = state_reg;
        ram_wr_en  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (s_tuser[0])
                        state_next = ST_TICK;
                    else if (is_on)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_TICK:
                state_next = ST_DONE;
            ST_SCAN:
            begin
                if (iss_reg == LAST_IDX)
                    state_next = ST_LAST;
            end
            ST_LAST:
                state_next = ST_WRITE;
            ST_WRITE:
            begin
                ram_wr_en  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            stick_reg      <= 5'sd0;
            last_on_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            iss_reg        <= '0;
            pend_reg       <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (in_acc)
            begin
                iss_reg        <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end

            if (state_reg == ST_TICK && cfg.feature_enable)
            begin
                stick_reg <= s_new[4:0];
                if (on_new != last_on_reg)
                begin
                    last_on_reg <= on_new;
                    if (on_new)
                        valid_reg <= '0;
                end
            end

            if (state_reg == ST_SCAN)
            begin
                if (iss_reg != LAST_IDX)
                    iss_reg <= iss_reg + 1'b1;
            end
            pend_reg <= (state_reg == ST_SCAN);

            // compare the entry read in the previous cycle
            if (pend_reg)
            begin
                if (valid_reg[pend_idx_reg] && !hit_found_reg &&
                    ram_rd_data[TUPLE_W-1:0] == item_tuple_reg)
                    hit_found_reg <= 1'b1;
                if (!valid_reg[pend_idx_reg])
                    free_found_reg <= 1'b1;
            end

            if (ram_wr_en)
                valid_reg[pick_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_tick_reg  <= s_tuser[0];
            item_tuple_reg <= s_tdata[95:0];
            item_ack_reg   <= s_tdata[127:96];
            item_time_reg  <= s_tdata[159:128];
            item_tx_reg    <= s_tdata[175:160];
            item_rx_reg    <= s_tdata[191:176];
            old_time_reg   <= TIME_MAX;
            res_dup_reg    <= 1'b0;
            res_slot_reg   <= '0;
            res_new_reg    <= 1'b0;
            res_chg_reg    <= 1'b0;
        end

        pend_idx_reg <= iss_reg;

        if (state_reg == ST_TICK && cfg.feature_enable)
            res_chg_reg <= (on_new != last_on_reg);

        if (pend_reg)
        begin
            if (valid_reg[pend_idx_reg] && !hit_found_reg &&
                ram_rd_data[TUPLE_W-1:0] == item_tuple_reg)
            begin
                hit_idx_reg <= pend_idx_reg;
                hit_dup_reg <= (ram_rd_data[TUPLE_W+31:TUPLE_W] == item_ack_reg);
            end
            if (!valid_reg[pend_idx_reg] && !free_found_reg)
                free_idx_reg <= pend_idx_reg;
            // ties go to the later slot
            if (ram_rd_data[ENTRY_W-1:TUPLE_W+32] <= old_time_reg)
            begin
                old_time_reg <= ram_rd_data[ENTRY_W-1:TUPLE_W+32];
                old_idx_reg  <= pend_idx_reg;
            end
        end

        if (ram_wr_en)
        begin
            res_dup_reg  <= hit_found_reg & hit_dup_reg;
            res_slot_reg <= pick_wide[SLOT_W-1:0];
            res_new_reg  <= ~hit_found_reg;
        end

        if (out_load)
            m_data_reg <= {is_on, res_chg_reg & item_tick_reg, res_new_reg,
                           res_slot_reg, res_dup_reg};
    end

    // a new entry never reports a duplicate
    a_new_not_dup: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[6] && m_tdata[0]))
        else $error("new flow reported as duplicate");

    // a new entry is only installed while on
    a_new_when_on: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6] |-> m_tdata[8])
        else $error("flow installed while off");

    // eviction only happens with a full table
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) && !hit_found_reg && !free_found_reg |-> &valid_reg)
        else $error("eviction with a free slot left");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

endmodule

// ===== rtl/tdaft_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdaft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tdaft_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the flow table.
// Depends on tdaft_pkg.
module tdaft_regs
    import tdaft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output tdaft_cfg_t            cfg
);

    tdaft_cfg_t cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.feature_enable   <= RST_FEATURE;
            cfg_reg.lower_bound_mbps <= RST_LOWER;
            cfg_reg.upper_bound_mbps <= RST_UPPER;
            cfg_reg.stick_ceiling    <= RST_CEILING;
            cfg_reg.stick_floor      <= RST_FLOOR;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FEATURE: cfg_reg.feature_enable   <= pwdata[0];
                REG_LOWER:   cfg_reg.lower_bound_mbps <= pwdata[15:0];
                REG_UPPER:   cfg_reg.upper_bound_mbps <= pwdata[15:0];
                REG_CEILING: cfg_reg.stick_ceiling    <= pwdata[3:0];
                REG_FLOOR:   cfg_reg.stick_floor      <= pwdata[4:0];
                default:     ; // drop writes beyond the map
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FEATURE: prdata = {31'd0, cfg_reg.feature_enable};
            REG_LOWER:   prdata = {16'd0, cfg_reg.lower_bound_mbps};
            REG_UPPER:   prdata = {16'd0, cfg_reg.upper_bound_mbps};
            REG_CEILING: prdata = {28'd0, cfg_reg.stick_ceiling};
            REG_FLOOR:   prdata = {{27{cfg_reg.stick_floor[4]}}, cfg_reg.stick_floor};
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== tb/tb_tcp_dup_ack_flow_table.sv =====
`timescale 1ns / 1ps
// Testbench for tcp_dup_ack_flow_table: drives ACK and tick items on the stream port, sets
// the throughput limits over the register port and checks each result against a local
// model of the flow table and stickiness switch. Depends on tdaft_pkg and the RTL only.
module tb_tcp_dup_ack_flow_table;
    import tdaft_pkg::*;

    localparam int   FLOW_SLOTS  = 32;
    localparam int   POOL_FLOWS  = 40;
    localparam int   HOLD_CYCLES = 300;
    localparam int   IDLE_PCT    = 18;
    localparam logic REQ_ACK     = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // laid out as s_tdata, last field in the lowest bits
    typedef struct packed {
        logic [15:0] rx_mbps;
        logic [15:0] tx_mbps;
        logic [31:0] time_ms;
        logic [31:0] ack_number;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
    } seg_item_t;

    typedef struct packed {
        logic [6:0] pad;
        logic       buffering_on;
        logic       status_changed;
        logic       new_flow;
        logic [4:0] flow_slot;
        logic       duplicate_ack;
    } verdict_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [191:0]          s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // local copy of the block's state and registers
    tdaft_cfg_t  model_cfg;
    logic        flow_valid  [FLOW_SLOTS];
    logic [31:0] flow_sip    [FLOW_SLOTS];
    logic [31:0] flow_dip    [FLOW_SLOTS];
    logic [15:0] flow_sport  [FLOW_SLOTS];
    logic [15:0] flow_dport  [FLOW_SLOTS];
    logic [31:0] flow_ack    [FLOW_SLOTS];
    logic [31:0] flow_time   [FLOW_SLOTS];
    int          stick_level;
    logic        on_state;

    verdict_t    verdicts_due[$];
    verdict_t    due_verdict;
    verdict_t    seen_verdict;
    int          fault_count  = 0;
    int          results_seen = 0;
    int          stall_left   = 0;
    logic        hold_off_req = 1'b0;
    logic        quiet_mode   = 1'b0;
    logic [31:0] clock_ms     = 32'd100;

    logic [31:0] pool_sip   [POOL_FLOWS];
    logic [31:0] pool_dip   [POOL_FLOWS];
    logic [15:0] pool_sport [POOL_FLOWS];
    logic [15:0] pool_dport [POOL_FLOWS];
    logic [31:0] pool_ack   [POOL_FLOWS];

    tcp_dup_ack_flow_table #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic verdict_t predict_verdict(input logic kind, input seg_item_t item);
        verdict_t    v;
        int          tp;
        int          lvl;
        int          floor_lvl;
        int          hit;
        int          slot;
        int          i;
        logic [31:0] oldest;
        v = '0;
        if (kind == REQ_TICK)
        begin
            if (model_cfg.feature_enable)
            begin
                tp = (item.tx_mbps > item.rx_mbps) ? int'(item.tx_mbps) : int'(item.rx_mbps);
                floor_lvl = $signed(model_cfg.stick_floor);
                if (tp > int'(model_cfg.lower_bound_mbps) &&
                    tp < int'(model_cfg.upper_bound_mbps))
                begin
                    lvl = stick_level + 1;
                    if (lvl > int'(model_cfg.stick_ceiling))
                        lvl = int'(model_cfg.stick_ceiling);
                end
                else
                begin
                    lvl = stick_level - 1;
                    if (lvl < floor_lvl)
                        lvl = floor_lvl;
                end
                stick_level = lvl;
                if ((stick_level > 0) != on_state)
                begin
                    on_state = (stick_level > 0);
                    v.status_changed = 1'b1;
                    // switching on starts with an empty table
                    if (on_state)
                        for (i = 0; i < FLOW_SLOTS; i++)
                            flow_valid[i] = 1'b0;
                end
            end
        end
        else if (stick_level > 0)
        begin
            hit = -1;
            for (i = 0; i < FLOW_SLOTS; i++)
                if (hit < 0 && flow_valid[i] && flow_sip[i] == item.source_ip &&
                    flow_dip[i] == item.dest_ip && flow_sport[i] == item.source_port &&
                    flow_dport[i] == item.dest_port)
                    hit = i;
            if (hit >= 0)
            begin
                slot = hit;
                v.duplicate_ack = (flow_ack[slot] == item.ack_number);
            end
            else
            begin
                slot = -1;
                for (i = 0; i < FLOW_SLOTS; i++)
                    if (slot < 0 && !flow_valid[i])
                        slot = i;
                // full table: evict the oldest, the higher index wins a tie
                if (slot < 0)
                begin
                    oldest = 32'hffff_ffff;
                    for (i = 0; i < FLOW_SLOTS; i++)
                        if (flow_time[i] <= oldest)
                        begin
                            oldest = flow_time[i];
                            slot   = i;
                        end
                end
                flow_valid[slot] = 1'b1;
                flow_sip[slot]   = item.source_ip;
                flow_dip[slot]   = item.dest_ip;
                flow_sport[slot] = item.source_port;
                flow_dport[slot] = item.dest_port;
                v.new_flow       = 1'b1;
            end
            flow_ack[slot]  = item.ack_number;
            flow_time[slot] = item.time_ms;
            v.flow_slot     = slot[4:0];
        end
        v.buffering_on = (stick_level > 0);
        return v;
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
        if (got !== want)
            report_fault($sformatf("result %0d %s: expected %0d, got %0d",
                                   results_seen, name, want, got));
    endtask

    // receiver: random stalls, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            stall_left <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= quiet_mode || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            results_seen++;
            if (verdicts_due.size() == 0)
                report_fault($sformatf("result %0d arrived with none due: m_tdata %h",
                                       results_seen, m_tdata));
            else
            begin
                due_verdict  = verdicts_due.pop_front();
                seen_verdict = m_tdata;
                check_field("duplicate_ack", due_verdict.duplicate_ack,
                            seen_verdict.duplicate_ack);
                check_field("flow_slot", due_verdict.flow_slot, seen_verdict.flow_slot);
                check_field("new_flow", due_verdict.new_flow, seen_verdict.new_flow);
                check_field("status_changed", due_verdict.status_changed,
                            seen_verdict.status_changed);
                check_field("buffering_on", due_verdict.buffering_on,
                            seen_verdict.buffering_on);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_FEATURE: model_cfg.feature_enable   = value[0];
            REG_LOWER:   model_cfg.lower_bound_mbps = value[15:0];
            REG_UPPER:   model_cfg.upper_bound_mbps = value[15:0];
            REG_CEILING: model_cfg.stick_ceiling    = value[3:0];
            REG_FLOOR:   model_cfg.stick_floor      = value[4:0];
            default:     ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input logic feature, input int lower, input int upper,
                              input int ceiling, input int floor_val);
        write_reg(REG_FEATURE, {31'd0, feature});
        write_reg(REG_LOWER, lower);
        write_reg(REG_UPPER, upper);
        write_reg(REG_CEILING, ceiling);
        write_reg(REG_FLOOR, {27'd0, floor_val[4:0]});
    endtask

    // hold tvalid across back-to-back items; lower it only for random idle gaps
    task automatic send_item(input logic kind, input seg_item_t item);
        while (!quiet_mode && $urandom_range(99, 0) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= item;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        verdicts_due.push_back(predict_verdict(kind, item));
    endtask

    function automatic seg_item_t random_item();
        seg_item_t it;
        it.source_ip   = $urandom;
        it.dest_ip     = $urandom;
        it.source_port = 16'($urandom);
        it.dest_port   = 16'($urandom);
        it.ack_number  = $urandom;
        it.time_ms     = $urandom;
        it.tx_mbps     = 16'($urandom);
        it.rx_mbps     = 16'($urandom);
        return it;
    endfunction

    task automatic send_tick(input logic [15:0] tx, input logic [15:0] rx);
        seg_item_t it;
        it         = random_item();
        it.tx_mbps = tx;
        it.rx_mbps = rx;
        send_item(REQ_TICK, it);
    endtask

    task automatic send_ack(input logic [31:0] sip, input logic [31:0] dip,
                            input logic [15:0] sport, input logic [15:0] dport,
                            input logic [31:0] ack, input logic [31:0] stamp);
        seg_item_t it;
        it             = random_item();
        it.source_ip   = sip;
        it.dest_ip     = dip;
        it.source_port = sport;
        it.dest_port   = dport;
        it.ack_number  = ack;
        it.time_ms     = stamp;
        send_item(REQ_ACK, it);
    endtask

    // mostly rising time with ties, now and then a jump or an extreme
    function automatic logic [31:0] next_time();
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 3)
            return 32'd0;
        if (pick < 6)
            return 32'hffff_ffff;
        if (pick < 14)
            return $urandom;
        clock_ms = clock_ms + $urandom_range(3, 0);
        return clock_ms;
    endfunction

    task automatic refill_pool();
        int k;
        for (k = 0; k < POOL_FLOWS; k++)
        begin
            pool_sip[k]   = $urandom;
            pool_dip[k]   = $urandom;
            pool_sport[k] = 16'($urandom);
            pool_dport[k] = 16'($urandom);
            pool_ack[k]   = $urandom;
        end
    endtask

    task automatic random_ack();
        int k;
        if ($urandom_range(99, 0) < 85)
        begin
            k = $urandom_range(POOL_FLOWS - 1, 0);
            if ($urandom_range(1, 0) == 0)
                pool_ack[k] = $urandom;
            send_ack(pool_sip[k], pool_dip[k], pool_sport[k], pool_dport[k], pool_ack[k],
                     next_time());
        end
        else
            send_ack($urandom, $urandom, 16'($urandom), 16'($urandom), $urandom,
                     next_time());
    endtask

    task automatic random_tick();
        int lo;
        int hi;
        int tp;
        int other;
        lo = int'(model_cfg.lower_bound_mbps);
        hi = int'(model_cfg.upper_bound_mbps);
        if (hi - lo >= 2 && $urandom_range(99, 0) < 75)
        begin
            tp    = $urandom_range(hi - 1, lo + 1);
            other = $urandom_range(tp, 0);
        end
        else
        begin
            tp    = $urandom_range(16'hffff, 0);
            other = $urandom_range(16'hffff, 0);
        end
        if ($urandom_range(1, 0) == 0)
            send_tick(16'(tp), 16'(other));
        else
            send_tick(16'(other), 16'(tp));
    endtask

    task automatic run_traffic(input int count, input int tick_pct);
        repeat (count)
        begin
            if ($urandom_range(99, 0) < tick_pct)
                random_tick();
            else
                random_ack();
        end
    endtask

    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // register defaults: feature off, so ticks change nothing and ACKs pass through
    task automatic test_after_reset();
        send_tick(16'd30, 16'd0);
        send_ack(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff,
                 32'hffff_ffff);
        send_ack(32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        finish_phase();
    endtask

    task automatic test_directed_switching();
        set_limits(1'b1, 5, 55, 10, -2);
        send_tick(16'd6, 16'd0);
        send_tick(16'd0, 16'd54);
        send_ack(32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        send_ack(32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd1);
        send_ack(32'd0, 32'd0, 16'd0, 16'd0, 32'hffff_ffff, 32'd2);
        send_ack(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff,
                 32'hffff_ffff);
        send_ack(32'd0, 32'd0, 16'd0, 16'hffff, 32'd7, 32'd3);
        // bounds are exclusive on both sides
        send_tick(16'd5, 16'd5);
        send_tick(16'd55, 16'd0);
        send_ack(32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd4);
        send_tick(16'hffff, 16'hffff);
        send_tick(16'd0, 16'd0);
        send_tick(16'd0, 16'd0);
        repeat (3)
            send_tick(16'd20, 16'd20);
        // the table was cleared on the way back on
        send_ack(32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd5);
        send_ack(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff, 32'd6);
        finish_phase();
    endtask

    // fill the table, mostly with equal timestamps, then force evictions among the ties
    task automatic test_eviction_order();
        int n;
        repeat (3)
            send_tick(16'd30, 16'd0);
        for (n = 0; n < FLOW_SLOTS + 2; n++)
            send_ack($urandom, $urandom, 16'($urandom), 16'($urandom), $urandom,
                     (n < FLOW_SLOTS) ? 32'd0 : 32'd1);
        finish_phase();
    endtask

    task automatic test_random_defaults();
        set_limits(1'b1, 5, 55, 10, -2);
        refill_pool();
        run_traffic(80, 20);
        finish_phase();
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        run_traffic(12, 20);
        finish_phase();
    endtask

    task automatic test_wide_bounds();
        set_limits(1'b1, 0, 65535, 15, -16);
        quiet_mode = 1'b1;
        run_traffic(80, 20);
        finish_phase();
        quiet_mode = 1'b0;
    endtask

    task automatic test_tight_switch();
        set_limits(1'b1, 1000, 2000, 1, 0);
        run_traffic(70, 40);
        finish_phase();
    endtask

    task automatic test_feature_disabled();
        set_limits(1'b0, 65535, 0, 4, -5);
        run_traffic(40, 30);
        finish_phase();
    endtask

    task automatic test_empty_window();
        set_limits(1'b1, 65535, 0, 4, -5);
        run_traffic(30, 30);
        finish_phase();
    endtask

    task automatic test_mid_window();
        set_limits(1'b1, 100, 200, 7, -1);
        refill_pool();
        run_traffic(80, 25);
        finish_phase();
    endtask

    initial
    begin
        model_cfg.feature_enable   = RST_FEATURE;
        model_cfg.lower_bound_mbps = RST_LOWER;
        model_cfg.upper_bound_mbps = RST_UPPER;
        model_cfg.stick_ceiling    = RST_CEILING;
        model_cfg.stick_floor      = RST_FLOOR;
        for (int i = 0; i < FLOW_SLOTS; i++)
            flow_valid[i] = 1'b0;
        stick_level = 0;
        on_state    = 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_directed_switching();
        test_eviction_order();
        test_random_defaults();
        test_backpressure();
        test_wide_bounds();
        test_tight_switch();
        test_feature_disabled();
        test_empty_window();
        test_mid_window();
        repeat (FLOW_SLOTS + 8)
            @(posedge clk);
        if (fault_count == 0 && verdicts_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tdaft_pkg.sv
rtl/tdaft_ram.sv
rtl/tdaft_regs.sv
rtl/tcp_dup_ack_flow_table.sv
tb/tb_tcp_dup_ack_flow_table.sv
